// ===== rtl/simplex_aspect_ratio_marker_defines.svh =====
// ----------------------------------------------------------------------------
// Simplex aspect-ratio marker assertion macros
// Concurrent check wrappers clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SIMPLEX_ASPECT_RATIO_MARKER_DEFINES_SVH
`define SIMPLEX_ASPECT_RATIO_MARKER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle property, checked at every edge out of reset
`define SARM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);
// Antecedent now, consequent in the next cycle
`define SARM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SARM_ASSERT(lbl, prop, msg)
`define SARM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/sarm_pkg.sv =====
// ----------------------------------------------------------------------------
// sarm_pkg
// Shared widths, register codes and job control type of the marker.
// ----------------------------------------------------------------------------
`default_nettype none

package sarm_pkg;

    localparam int COORD_W  = 24;
    localparam int GEN_W    = 8;
    localparam int DIM_W    = 2;
    localparam int LEVEL_W  = 8;
    localparam int THR_W    = 16;
    localparam int LEN_W    = 50;
    localparam int SPLIT_W  = 32;
    localparam int HI_W     = LEN_W - SPLIT_W;
    localparam int PROD_W   = THR_W + LEN_W;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 4;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = 1;
    localparam int QCNT_W   = 2;

    localparam logic [DIM_W-1:0]   DIM_RST   = 2'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_RST = 8'd0;
    localparam logic [THR_W-1:0]   THR_RST   = 16'd100;

    typedef enum logic [1:0] {
        REG_DIM   = 2'd0,
        REG_LEVEL = 2'd1,
        REG_THR   = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [DIM_W-1:0] dim;
        logic             skip;
        logic             last;
    } t_job_ctl;

endpackage

`default_nettype wire

// ===== rtl/sarm_vtx_if.sv =====
// ----------------------------------------------------------------------------
// sarm_vtx_if
// Vertex channel: one vertex word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface sarm_vtx_if import sarm_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] coord_a;
    logic signed [COORD_W-1:0] coord_b;
    logic signed [COORD_W-1:0] coord_c;
    logic [GEN_W-1:0]          generation;
    logic                      last_simplex;

    modport source (
        output valid, coord_a, coord_b, coord_c, generation, last_simplex,
        input  ready
    );
    modport sink (
        input  valid, coord_a, coord_b, coord_c, generation, last_simplex,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/sarm_res_if.sv =====
// ----------------------------------------------------------------------------
// sarm_res_if
// Result channel: one verdict word per completed simplex.
// ----------------------------------------------------------------------------
`default_nettype none

interface sarm_res_if import sarm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             marked;
    logic             skipped;
    logic [LEN_W-1:0] longest_edge_sq;
    logic [LEN_W-1:0] shortest_edge_sq;
    logic             pass_end;

    modport source (
        output valid, marked, skipped, longest_edge_sq, shortest_edge_sq, pass_end,
        input  ready
    );
    modport sink (
        input  valid, marked, skipped, longest_edge_sq, shortest_edge_sq, pass_end,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/simplex_aspect_ratio_marker.sv =====
// ----------------------------------------------------------------------------
// simplex_aspect_ratio_marker
// Marks simplices whose squared longest edge exceeds threshold times the
// squared shortest edge; reports skipped simplices below the current level.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake            Word
//  i_vtx     in   valid/ready          one vertex: coords, generation, last flag
//  o_res     out  valid/ready          one verdict per simplex
//  APB       in   psel/penable/pwrite  dimension, current level, threshold
//
//  Vertices are taken one per cycle while the job queue has room; only the
//  closing vertex of a simplex needs a free queue slot.
//  The back end works each simplex through the single squaring multiplier,
//  stepping over every coordinate of every edge; a skipped simplex goes
//  straight to the result register.
//  Reset is synchronous and clears control only; no clearing pass is run.
//  A stalled result holds in the output register while the back end runs on.
// ----------------------------------------------------------------------------
`default_nettype none
`include "simplex_aspect_ratio_marker_defines.svh"

module simplex_aspect_ratio_marker import sarm_pkg::*; #(
    parameter int MAX_DIM    = 3,
    parameter int COORD_BITS = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sarm_vtx_if.sink          i_vtx,
    sarm_res_if.source        o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int PTS_W  = (MAX_DIM + 1) * MAX_DIM * COORD_BITS;
    localparam int CTL_W  = $bits(t_job_ctl);
    localparam int DATA_W = CTL_W + PTS_W;

    logic [DIM_W-1:0]   r_dim;
    logic [LEVEL_W-1:0] r_level;
    logic [THR_W-1:0]   r_thr;
    logic [DIM_W-1:0]   w_eff_dim;
    logic               w_wr;
    logic               w_dim_wr;

    logic                                          w_push;
    logic                                          w_pop;
    logic                                          w_q_full;
    logic                                          w_q_empty;
    logic [MAX_DIM:0][MAX_DIM-1:0][COORD_BITS-1:0] w_push_pts;
    logic [MAX_DIM:0][MAX_DIM-1:0][COORD_BITS-1:0] w_pop_pts;
    t_job_ctl                                      w_push_ctl;
    t_job_ctl                                      w_pop_ctl;
    logic [DATA_W-1:0]                             w_q_wdata;
    logic [DATA_W-1:0]                             w_q_rdata;

    // ---------------------------------------------------------------- APB --
    assign pready   = 1'b1;
    assign w_wr     = psel && penable && pwrite;
    assign w_dim_wr = w_wr && (paddr[3:2] == REG_DIM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim   <= DIM_RST;
            r_level <= LEVEL_RST;
            r_thr   <= THR_RST;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_DIM:   r_dim   <= pwdata[DIM_W-1:0];
                REG_LEVEL: r_level <= pwdata[LEVEL_W-1:0];
                REG_THR:   r_thr   <= pwdata[THR_W-1:0];
                default:   r_thr   <= r_thr;  // drop writes to unused addresses
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_DIM:   prdata = APB_DW'(r_dim);
            REG_LEVEL: prdata = APB_DW'(r_level);
            REG_THR:   prdata = APB_DW'(r_thr);
            default:   prdata = '0;
        endcase
    end

    // Clamp the dimension: zero acts as one, above MAX_DIM as MAX_DIM
    always_comb begin
        if (r_dim == '0) begin
            w_eff_dim = DIM_W'(1);
        end else if (r_dim > DIM_W'(MAX_DIM)) begin
            w_eff_dim = DIM_W'(MAX_DIM);
        end else begin
            w_eff_dim = r_dim;
        end
    end

    // -------------------------------------------------------------- front --
    sarm_front #(
        .MAX_DIM    (MAX_DIM),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vtx     (i_vtx),
        .i_dim     (w_eff_dim),
        .i_level   (r_level),
        .i_clr     (w_dim_wr),
        .i_q_full  (w_q_full),
        .o_push    (w_push),
        .o_job_pts (w_push_pts),
        .o_job_ctl (w_push_ctl)
    );

    // -------------------------------------------------------------- queue --
    assign w_q_wdata = {w_push_ctl, w_push_pts};
    assign w_pop_ctl = t_job_ctl'(w_q_rdata[DATA_W-1 -: CTL_W]);
    assign w_pop_pts = w_q_rdata[PTS_W-1:0];

    sarm_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_wdata),
        .i_pop   (w_pop),
        .o_data  (w_q_rdata),
        .o_empty (w_q_empty),
        .o_full  (w_q_full)
    );

    // --------------------------------------------------------------- back --
    sarm_back #(
        .MAX_DIM    (MAX_DIM),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job_pts (w_pop_pts),
        .i_job_ctl (w_pop_ctl),
        .i_q_empty (w_q_empty),
        .o_pop     (w_pop),
        .i_thr     (r_thr),
        .o_res     (o_res)
    );

    // --------------------------------------------------------- assertions --
    `SARM_ASSERT(a_push_room, w_push |-> !w_q_full, "job pushed into a full queue")
    `SARM_ASSERT(a_pop_data, w_pop |-> !w_q_empty, "job popped from an empty queue")
    `SARM_ASSERT_NEXT(a_queue_fill, w_push && w_q_empty && !w_pop, !w_q_empty, "pushed job lost")
    `SARM_ASSERT(a_skip_clean, o_res.valid && o_res.skipped |-> !o_res.marked && o_res.longest_edge_sq == '0 && o_res.shortest_edge_sq == '0, "skipped verdict carries data")

endmodule

`default_nettype wire

// ===== rtl/sarm_front.sv =====
// ----------------------------------------------------------------------------
// sarm_front
// Gather vertices, classify the simplex and emit one job on its last vertex.
// ----------------------------------------------------------------------------
`default_nettype none

module sarm_front import sarm_pkg::*; #(
    parameter int MAX_DIM    = 3,
    parameter int COORD_BITS = 24
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    sarm_vtx_if.sink                                  i_vtx,
    input  logic [DIM_W-1:0]                          i_dim,
    input  logic [LEVEL_W-1:0]                        i_level,
    input  logic                                      i_clr,
    input  logic                                      i_q_full,
    output logic                                      o_push,
    output logic [MAX_DIM:0][MAX_DIM-1:0][COORD_BITS-1:0] o_job_pts,
    output t_job_ctl                                  o_job_ctl
);

    logic [DIM_W-1:0]                    r_count;
    logic [DIM_W-1:0]                    n_count;
    logic [COORD_BITS-1:0]               r_store [MAX_DIM][MAX_DIM];
    logic [MAX_DIM-1:0][COORD_BITS-1:0]  w_vin;
    logic                                w_complete;
    logic                                w_accept;

    // Low COORD_BITS of each used coordinate
    always_comb begin
        for (int p = 0; p < MAX_DIM; p++) begin
            if (p == 0) begin
                w_vin[p] = i_vtx.coord_a[COORD_BITS-1:0];
            end else if (p == 1) begin
                w_vin[p] = i_vtx.coord_b[COORD_BITS-1:0];
            end else begin
                w_vin[p] = i_vtx.coord_c[COORD_BITS-1:0];
            end
        end
    end

    assign w_complete  = (r_count == i_dim);
    assign i_vtx.ready = !w_complete || !i_q_full;
    assign w_accept    = i_vtx.valid && i_vtx.ready;
    assign o_push      = w_accept && w_complete;

    always_comb begin
        n_count = r_count;
        if (i_clr) begin
            n_count = '0;
        end else if (w_accept) begin
            n_count = w_complete ? '0 : DIM_W'(r_count + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Hold earlier vertices of the simplex
    always_ff @(posedge i_clk) begin
        if (w_accept && !w_complete) begin
            for (int v = 0; v < MAX_DIM; v++) begin
                if (r_count == DIM_W'(v)) begin
                    for (int p = 0; p < MAX_DIM; p++) begin
                        r_store[v][p] <= w_vin[p];
                    end
                end
            end
        end
    end

    // The closing vertex lands in row dim
    for (genvar v = 0; v < MAX_DIM; v++) begin : g_row
        for (genvar p = 0; p < MAX_DIM; p++) begin : g_col
            assign o_job_pts[v][p] = (i_dim == DIM_W'(v)) ? w_vin[p] : r_store[v][p];
        end
    end
    assign o_job_pts[MAX_DIM] = w_vin;

    assign o_job_ctl.dim  = i_dim;
    assign o_job_ctl.skip = (i_vtx.generation < i_level);
    assign o_job_ctl.last = i_vtx.last_simplex;

endmodule

`default_nettype wire

// ===== rtl/sarm_queue.sv =====
// ----------------------------------------------------------------------------
// sarm_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module sarm_queue import sarm_pkg::*; #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty,
    output logic              o_full
);

    logic [DATA_W-1:0] r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= QPTR_W'(r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= QPTR_W'(r_rd_ptr + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= QCNT_W'(r_cnt + 1'b1);
            end else if (i_pop && !i_push) begin
                r_cnt <= QCNT_W'(r_cnt - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sarm_back.sv =====
// ----------------------------------------------------------------------------
// sarm_back
// Edge-length sequencer, ratio test and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sarm_back import sarm_pkg::*; #(
    parameter int MAX_DIM    = 3,
    parameter int COORD_BITS = 24
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic [MAX_DIM:0][MAX_DIM-1:0][COORD_BITS-1:0] i_job_pts,
    input  t_job_ctl                                  i_job_ctl,
    input  logic                                      i_q_empty,
    output logic                                      o_pop,
    input  logic [THR_W-1:0]                          i_thr,
    sarm_res_if.source                                o_res
);

    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int SUM_W = 2 * COORD_BITS + 2;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SQ   = 7'b0000010,
        S_ACC  = 7'b0000100,
        S_MLO  = 7'b0001000,
        S_MHI  = 7'b0010000,
        S_CMP  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_bstate;

    t_bstate                                   r_state;
    t_bstate                                   n_state;
    logic [MAX_DIM:0][MAX_DIM-1:0][COORD_BITS-1:0] r_pts;
    logic [DIM_W-1:0]                          r_dim;
    logic                                      r_skip;
    logic                                      r_last;
    logic [DIM_W-1:0]                          r_i;
    logic [DIM_W-1:0]                          r_j;
    logic [DIM_W-1:0]                          r_p;
    logic                                      r_first;
    logic [SQ_W-1:0]                           r_sq;
    logic [SUM_W-1:0]                          r_acc;
    logic [LEN_W-1:0]                          r_long;
    logic [LEN_W-1:0]                          r_short;
    logic [THR_W+SPLIT_W-1:0]                  r_plo;
    logic [THR_W+HI_W-1:0]                     r_phi;
    logic                                      r_marked;
    logic                                      r_o_vld;
    logic                                      r_o_marked;
    logic                                      r_o_skip;
    logic [LEN_W-1:0]                          r_o_long;
    logic [LEN_W-1:0]                          r_o_short;
    logic                                      r_o_end;

    logic [COORD_BITS-1:0]   w_ca;
    logic [COORD_BITS-1:0]   w_cb;
    logic signed [COORD_BITS:0] w_diff;
    logic [COORD_BITS:0]     w_neg;
    logic [COORD_BITS-1:0]   w_mag;
    logic [SUM_W-1:0]        w_sum;
    logic [LEN_W-1:0]        w_sum_ext;
    logic                    w_edge_last;
    logic                    w_all_done;
    logic [PROD_W-1:0]       w_prod;
    logic                    w_marked;
    logic                    w_o_free;

    // Pick coordinate p of vertices i and j
    always_comb begin
        w_ca = '0;
        w_cb = '0;
        for (int v = 0; v <= MAX_DIM; v++) begin
            for (int p = 0; p < MAX_DIM; p++) begin
                if (r_i == DIM_W'(v) && r_p == DIM_W'(p)) begin
                    w_ca = r_pts[v][p];
                end
                if (r_j == DIM_W'(v) && r_p == DIM_W'(p)) begin
                    w_cb = r_pts[v][p];
                end
            end
        end
    end

    assign w_diff = $signed({w_ca[COORD_BITS-1], w_ca}) - $signed({w_cb[COORD_BITS-1], w_cb});
    assign w_neg  = -w_diff;
    assign w_mag  = w_diff[COORD_BITS] ? w_neg[COORD_BITS-1:0] : w_diff[COORD_BITS-1:0];

    assign w_sum       = r_acc + SUM_W'(r_sq);
    assign w_sum_ext   = LEN_W'(w_sum);
    assign w_edge_last = (r_p == DIM_W'(r_dim - 1'b1));
    assign w_all_done  = (r_j == r_dim) && (r_i == DIM_W'(r_dim - 1'b1));
    assign w_prod      = (PROD_W'(r_phi) << SPLIT_W) + PROD_W'(r_plo);
    assign w_marked    = (PROD_W'(r_long) > w_prod);
    assign w_o_free    = !r_o_vld || o_res.ready;
    assign o_pop       = (r_state == S_IDLE) && !i_q_empty;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_state = i_job_ctl.skip ? S_DONE : S_SQ;
                end
            end
            S_SQ:   n_state = S_ACC;
            S_ACC: begin
                if (w_edge_last && w_all_done) begin
                    n_state = S_MLO;
                end else begin
                    n_state = S_SQ;
                end
            end
            S_MLO:  n_state = S_MHI;
            S_MHI:  n_state = S_CMP;
            S_CMP:  n_state = S_DONE;
            S_DONE: begin
                if (w_o_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_o_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && w_o_free) begin
                r_o_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    r_pts    <= i_job_pts;
                    r_dim    <= i_job_ctl.dim;
                    r_skip   <= i_job_ctl.skip;
                    r_last   <= i_job_ctl.last;
                    r_i      <= '0;
                    r_j      <= DIM_W'(1);
                    r_p      <= '0;
                    r_first  <= 1'b1;
                    r_acc    <= '0;
                    r_long   <= '0;
                    r_short  <= '0;
                    r_marked <= 1'b0;
                end
            end
            S_SQ: begin
                r_sq <= w_mag * w_mag;
            end
            S_ACC: begin
                if (w_edge_last) begin
                    r_acc   <= '0;
                    r_p     <= '0;
                    r_first <= 1'b0;
                    if (r_first) begin
                        r_long  <= w_sum_ext;
                        r_short <= w_sum_ext;
                    end else begin
                        if (w_sum_ext > r_long) begin
                            r_long <= w_sum_ext;
                        end
                        if (w_sum_ext < r_short) begin
                            r_short <= w_sum_ext;
                        end
                    end
                    // advance to the next vertex pair
                    if (r_j == r_dim) begin
                        r_i <= DIM_W'(r_i + 1'b1);
                        r_j <= DIM_W'(r_i + 2'd2);
                    end else begin
                        r_j <= DIM_W'(r_j + 1'b1);
                    end
                end else begin
                    r_acc <= w_sum;
                    r_p   <= DIM_W'(r_p + 1'b1);
                end
            end
            S_MLO: begin
                r_plo <= i_thr * r_short[SPLIT_W-1:0];
            end
            S_MHI: begin
                r_phi <= i_thr * r_short[LEN_W-1:SPLIT_W];
            end
            S_CMP: begin
                r_marked <= w_marked;
            end
            S_DONE: begin
                if (w_o_free) begin
                    r_o_marked <= r_marked;
                    r_o_skip   <= r_skip;
                    r_o_long   <= r_long;
                    r_o_short  <= r_short;
                    r_o_end    <= r_last;
                end
            end
            default: begin
                r_acc <= '0;
            end
        endcase
    end

    assign o_res.valid            = r_o_vld;
    assign o_res.marked           = r_o_marked;
    assign o_res.skipped          = r_o_skip;
    assign o_res.longest_edge_sq  = r_o_long;
    assign o_res.shortest_edge_sq = r_o_short;
    assign o_res.pass_end         = r_o_end;

endmodule

`default_nettype wire
